// ===== design/psu_ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// PSU output fault supervisor package
// Types, register indexes, command codes and limits shared by the supervisor.
// ----------------------------------------------------------------------------
package psu_ofs_pkg;

  localparam int StartupTicks  = 100;
  localparam int TempQualTicks = 3;
  localparam int FuseQualTicks = 2;
  localparam int DevQualTicks  = 3;

  localparam logic [6:0] STARTUP_LIM   = 7'(StartupTicks);
  localparam logic [1:0] TEMP_QUAL_LIM = (TempQualTicks > 3) ? 2'd3 : 2'(TempQualTicks);
  localparam logic [1:0] FUSE_QUAL_LIM = (FuseQualTicks > 3) ? 2'd3 : 2'(FuseQualTicks);
  localparam logic [1:0] DEV_QUAL_LIM  = (DevQualTicks > 3) ? 2'd3 : 2'(DevQualTicks);

  localparam logic signed [11:0] SENSOR_HI = 12'sd1000;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_RESTART = 2'd3
  } user_cmd_t;

  typedef enum logic [2:0] {
    REG_TEMP_LIMIT  = 3'd0,
    REG_FUSE_CUT    = 3'd1,
    REG_CURRENT_MAX = 3'd2,
    REG_POWER_MAX   = 3'd3,
    REG_VOUT_MAX    = 3'd4,
    REG_VOUT_MIN    = 3'd5,
    REG_VDEV_LIMIT  = 3'd6,
    REG_IDEV_MARGIN = 3'd7
  } cfg_index_t;

  // Bit positions in the fault flag vector.
  localparam int FLG_TEMP = 0;
  localparam int FLG_FUSE = 1;
  localparam int FLG_OVI  = 2;
  localparam int FLG_OVP  = 3;
  localparam int FLG_VOUT = 4;
  localparam int FLG_VDEV = 5;
  localparam int FLG_CDEV = 6;
  localparam int FLG_SENS = 7;

  typedef struct packed {
    logic signed [11:0] temperature;
    logic [15:0]        voltage;
    logic [15:0]        current;
    logic [19:0]        power;
    logic [15:0]        voltage_target;
    logic [15:0]        current_target;
    logic               meas_valid;
    logic               constant_current;
    logic               auto_mode;
    logic               init_fail;
    user_cmd_t          user_command;
  } in_item_t;

  typedef struct packed {
    logic       output_on;
    logic       enable_latched;
    logic       starting;
    logic [7:0] flags;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       flag;
  } qual_t;

  // A qualification counter counts up to its limit while the condition holds.
  function automatic qual_t qualify(input logic cond, input logic [1:0] cnt,
                                    input logic [1:0] lim);
    qual_t q;
    if (cond) begin
      q.cnt  = (cnt < lim) ? cnt + 2'd1 : cnt;
      q.flag = (q.cnt >= lim);
    end else begin
      q.cnt  = 2'd0;
      q.flag = 1'b0;
    end
    return q;
  endfunction

endpackage

// ===== design/psu_output_fault_supervisor.sv =====
// ----------------------------------------------------------------------------
// PSU output fault supervisor
// Qualifies output faults of a power supply once per tick and drives the
// output switch from a user enable latch.
// ----------------------------------------------------------------------------
// Each item on the input stream is one supervision tick carrying the
// measurements, ramped targets, mode flags and the user command. For every
// item the block returns one result item with the switch drive, the latch,
// the startup indication and the fault flags.
// An accepted item is held in an input register; all checks run on it there,
// and the result is written to the output register as soon as that register
// is free or being emptied, from where it is offered to the receiver. One item
// per cycle is sustained while out_tready stays high; the rate is set by
// the single evaluation stage that reads and updates the supervision state.
// When the receiver stalls, the output register holds its item and the
// input register still takes one more item; after that in_tready drops.
// Reset empties both registers, clears all counters and flags and the user
// latch, restarts the startup hold and loads the register defaults.
// Configuration writes are taken at any clock edge with cfg_we high outside reset.
// ----------------------------------------------------------------------------
module psu_output_fault_supervisor
  import psu_ofs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // temperature, voltage, current, power, voltage_target, current_target,
  // constant_current, auto_mode, init_fail, user_command, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // meas_valid
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // output_on, enable_latched, starting, temp_fault, fuse_blown, over_current,
  // over_power, vout_out_of_range, voltage_dev, current_dev, sensor_fail,
  // zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [10:0] temp_limit_r;
  logic [15:0] fuse_cut_r;
  logic [15:0] current_max_r;
  logic [19:0] power_max_r;
  logic [15:0] vout_max_r;
  logic [15:0] vout_min_r;
  logic [15:0] vdev_limit_r;
  logic [7:0]  idev_margin_r;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  in_item_t  in_item;
  logic      s1_adv;

  logic [6:0] start_ticks_r, start_ticks_nxt;
  logic       start_hold_r, start_hold_nxt;
  logic [1:0] temp_qual_r, temp_qual_nxt;
  logic [1:0] fuse_qual_r, fuse_qual_nxt;
  logic [1:0] vdev_qual_r, vdev_qual_nxt;
  logic [1:0] cdev_qual_r, cdev_qual_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic       user_latch_r, user_latch_nxt;
  out_item_t  out_item_nxt;

  logic        restart;
  logic [6:0]  ticks_a, ticks_inc;
  logic        hold_a;
  logic [1:0]  fuse_qual_a, cdev_qual_a;
  logic [7:0]  flags_a;
  logic        latch_a;
  logic [15:0] vdiff;
  logic [23:0] cur_scaled;
  logic [24:0] tgt_scaled;
  logic        fault;
  qual_t       q_temp, q_fuse, q_vdev, q_cdev;

  assign in_item.temperature      = in_tdata[11:0];
  assign in_item.voltage          = in_tdata[27:12];
  assign in_item.current          = in_tdata[43:28];
  assign in_item.power            = in_tdata[63:44];
  assign in_item.voltage_target   = in_tdata[79:64];
  assign in_item.current_target   = in_tdata[95:80];
  assign in_item.constant_current = in_tdata[96];
  assign in_item.auto_mode        = in_tdata[97];
  assign in_item.init_fail        = in_tdata[98];
  assign in_item.user_command     = user_cmd_t'(in_tdata[100:99]);
  assign in_item.meas_valid       = in_tuser;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r  <= 11'd600;
      fuse_cut_r    <= 16'd0;
      current_max_r <= 16'hFFFF;
      power_max_r   <= 20'hFFFFF;
      vout_max_r    <= 16'hFFFF;
      vout_min_r    <= 16'd0;
      vdev_limit_r  <= 16'd1000;
      idev_margin_r <= 8'd26;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEMP_LIMIT:  temp_limit_r  <= cfg_wdata[10:0];
        REG_FUSE_CUT:    fuse_cut_r    <= cfg_wdata[15:0];
        REG_CURRENT_MAX: current_max_r <= cfg_wdata[15:0];
        REG_POWER_MAX:   power_max_r   <= cfg_wdata[19:0];
        REG_VOUT_MAX:    vout_max_r    <= cfg_wdata[15:0];
        REG_VOUT_MIN:    vout_min_r    <= cfg_wdata[15:0];
        REG_VDEV_LIMIT:  vdev_limit_r  <= cfg_wdata[15:0];
        REG_IDEV_MARGIN: idev_margin_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = (s1_item_r.user_command == CMD_RESTART);

    case (s1_item_r.user_command)
      CMD_ENABLE:  latch_a = 1'b1;
      CMD_DISABLE: latch_a = 1'b0;
      CMD_RESTART: latch_a = 1'b0;
      default:     latch_a = user_latch_r;
    endcase

    ticks_a     = restart ? 7'd0 : start_ticks_r;
    hold_a      = restart ? 1'b1 : start_hold_r;
    fuse_qual_a = restart ? 2'd0 : fuse_qual_r;
    cdev_qual_a = restart ? 2'd0 : cdev_qual_r;
    flags_a     = restart ? 8'd0 : flags_r;

    ticks_inc       = ticks_a + 7'd1;
    start_ticks_nxt = ticks_a;
    start_hold_nxt  = hold_a;
    if (hold_a) begin
      start_ticks_nxt = ticks_inc;
      if (ticks_inc >= STARTUP_LIM) begin
        start_hold_nxt  = 1'b0;
        start_ticks_nxt = STARTUP_LIM;
      end
    end

    flags_nxt = flags_a;
    flags_nxt[FLG_SENS] = (s1_item_r.temperature < 12'sd0) ||
                          (s1_item_r.temperature > SENSOR_HI);

    q_temp = qualify(s1_item_r.temperature >= $signed({1'b0, temp_limit_r}),
                     restart ? 2'd0 : temp_qual_r, TEMP_QUAL_LIM);
    temp_qual_nxt       = q_temp.cnt;
    flags_nxt[FLG_TEMP] = q_temp.flag;

    q_fuse = qualify(s1_item_r.current > fuse_cut_r, fuse_qual_a, FUSE_QUAL_LIM);
    fuse_qual_nxt = fuse_qual_a;
    if ((fuse_cut_r != 16'd0) && s1_item_r.meas_valid) begin
      fuse_qual_nxt       = q_fuse.cnt;
      flags_nxt[FLG_FUSE] = q_fuse.flag;
    end

    flags_nxt[FLG_OVI] = !start_hold_nxt && s1_item_r.meas_valid &&
                         (s1_item_r.current > current_max_r);
    flags_nxt[FLG_OVP] = !start_hold_nxt && s1_item_r.meas_valid &&
                         (s1_item_r.power > power_max_r);
    flags_nxt[FLG_VOUT] = !start_hold_nxt && s1_item_r.meas_valid &&
                          ((s1_item_r.voltage > vout_max_r) ||
                           (s1_item_r.voltage < vout_min_r));

    vdiff = (s1_item_r.voltage > s1_item_r.voltage_target) ?
            s1_item_r.voltage - s1_item_r.voltage_target :
            s1_item_r.voltage_target - s1_item_r.voltage;
    q_vdev = qualify(vdiff > vdev_limit_r, restart ? 2'd0 : vdev_qual_r, DEV_QUAL_LIM);
    if (!s1_item_r.auto_mode || start_hold_nxt || s1_item_r.constant_current ||
        !s1_item_r.meas_valid) begin
      vdev_qual_nxt       = 2'd0;
      flags_nxt[FLG_VDEV] = 1'b0;
    end else begin
      vdev_qual_nxt       = q_vdev.cnt;
      flags_nxt[FLG_VDEV] = q_vdev.flag;
    end

    cur_scaled = {s1_item_r.current, 8'd0};
    tgt_scaled = 25'(s1_item_r.current_target) * 25'({1'b1, idev_margin_r});
    q_cdev = qualify({1'b0, cur_scaled} > tgt_scaled, cdev_qual_a, DEV_QUAL_LIM);
    cdev_qual_nxt = cdev_qual_a;
    if (s1_item_r.auto_mode && s1_item_r.meas_valid) begin
      cdev_qual_nxt       = q_cdev.cnt;
      flags_nxt[FLG_CDEV] = q_cdev.flag;
    end

    fault          = (flags_nxt != 8'd0) || s1_item_r.init_fail;
    user_latch_nxt = latch_a && !fault;

    out_item_nxt.output_on      = latch_a && !fault;
    out_item_nxt.enable_latched = user_latch_nxt;
    out_item_nxt.starting       = start_hold_nxt;
    out_item_nxt.flags          = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      start_ticks_r <= 7'd0;
      start_hold_r  <= 1'b1;
      temp_qual_r   <= 2'd0;
      fuse_qual_r   <= 2'd0;
      vdev_qual_r   <= 2'd0;
      cdev_qual_r   <= 2'd0;
      flags_r       <= 8'd0;
      user_latch_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r   <= 1'b1;
        start_ticks_r <= start_ticks_nxt;
        start_hold_r  <= start_hold_nxt;
        temp_qual_r   <= temp_qual_nxt;
        fuse_qual_r   <= fuse_qual_nxt;
        vdev_qual_r   <= vdev_qual_nxt;
        cdev_qual_r   <= cdev_qual_nxt;
        flags_r       <= flags_nxt;
        user_latch_r  <= user_latch_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_item_r.flags[FLG_SENS],
                       out_item_r.flags[FLG_CDEV],
                       out_item_r.flags[FLG_VDEV],
                       out_item_r.flags[FLG_VOUT],
                       out_item_r.flags[FLG_OVP],
                       out_item_r.flags[FLG_OVI],
                       out_item_r.flags[FLG_FUSE],
                       out_item_r.flags[FLG_TEMP],
                       out_item_r.starting,
                       out_item_r.enable_latched,
                       out_item_r.output_on};

  a_on_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.output_on |-> out_item_r.enable_latched)
    else $error("output on without the user latch");

  a_on_needs_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.output_on |-> (out_item_r.flags == 8'd0))
    else $error("output on while a fault is flagged");

  a_no_limit_in_startup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.starting |->
      !(out_item_r.flags[FLG_OVI] || out_item_r.flags[FLG_OVP] ||
        out_item_r.flags[FLG_VOUT] || out_item_r.flags[FLG_VDEV]))
    else $error("absolute limit or voltage deviation flagged during startup");

  a_state_saved_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (user_latch_r == out_item_r.enable_latched) &&
               (start_hold_r == out_item_r.starting))
    else $error("supervision state and result disagree");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PSU output fault supervisor testbench
// Streams supervision ticks into the supervisor and checks every status item
// against a cycle-free predictor kept in the bench. Directed ticks cover the
// field extremes and the corner cases, then random fault episodes run under
// several register settings with random idling on both streams, a long
// receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import psu_ofs_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 2000;

  typedef enum int {
    FK_NONE, FK_TEMP, FK_FUSE, FK_OVI, FK_OVP, FK_VOUT, FK_VDEV, FK_CDEV, FK_INIT,
    FK_NOISE
  } fault_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  cfg_index_t            cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Register copies.
  logic [10:0] cfg_temp_limit;
  logic [15:0] cfg_fuse_cut;
  logic [15:0] cfg_current_max;
  logic [19:0] cfg_power_max;
  logic [15:0] cfg_vout_max;
  logic [15:0] cfg_vout_min;
  logic [15:0] cfg_vdev_limit;
  logic [7:0]  cfg_idev_margin;

  // Supervision state of the predictor.
  logic [6:0] sup_ticks;
  logic       sup_hold;
  logic [1:0] qual_temp;
  logic [1:0] qual_fuse;
  logic [1:0] qual_vdev;
  logic [1:0] qual_cdev;
  logic [7:0] sup_flags;
  logic       sup_latch;
  logic       sup_drive;

  out_item_t expected_status[$];
  in_item_t  cur_tick;
  int        errors;
  int        stall_cycles;
  bit        src_idle;
  bit        sink_idle;
  bit        hold_req;

  string flag_names[8] = '{"temp_fault", "fuse_blown", "over_current", "over_power",
                           "vout_out_of_range", "voltage_dev", "current_dev",
                           "sensor_fail"};

  psu_output_fault_supervisor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // temperature, voltage, current, power, voltage_target, current_target,
    // constant_current, auto_mode, init_fail, user_command, zero fill
    .in_tdata  (in_tdata),
    // meas_valid
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // output_on, enable_latched, starting, temp_fault, fuse_blown, over_current,
    // over_power, vout_out_of_range, voltage_dev, current_dev, sensor_fail,
    // zero fill
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic void clear_supervision();
    sup_ticks = '0;
    sup_hold  = 1'b1;
    qual_temp = '0;
    qual_fuse = '0;
    qual_vdev = '0;
    qual_cdev = '0;
    sup_flags = '0;
    sup_latch = 1'b0;
    sup_drive = 1'b0;
  endfunction

  function automatic void count_fault(input bit cond, inout logic [1:0] cnt,
                                      input logic [1:0] lim, input int flag_idx);
    if (cond) begin
      if (cnt < lim) cnt = cnt + 2'd1;
      if (cnt >= lim) sup_flags[flag_idx] = 1'b1;
    end else begin
      cnt = '0;
      sup_flags[flag_idx] = 1'b0;
    end
  endfunction

  function automatic out_item_t supervise_tick(input in_item_t t);
    out_item_t   r;
    int          temp_c;
    int          vdiff;
    logic [31:0] i_scaled;
    logic [31:0] i_allow;
    temp_c = int'($signed(t.temperature));
    case (t.user_command)
      CMD_ENABLE:  sup_latch = 1'b1;
      CMD_DISABLE: sup_latch = 1'b0;
      CMD_RESTART: clear_supervision();
      default: ;
    endcase
    if (sup_hold) begin
      sup_ticks = sup_ticks + 7'd1;
      if (sup_ticks >= STARTUP_LIM) begin
        sup_hold  = 1'b0;
        sup_ticks = STARTUP_LIM;
      end
    end
    sup_flags[FLG_SENS] = (temp_c < 0) || (temp_c > 1000);
    count_fault(temp_c >= int'(cfg_temp_limit), qual_temp, TEMP_QUAL_LIM, FLG_TEMP);
    if (cfg_fuse_cut != 16'd0 && t.meas_valid)
      count_fault(t.current > cfg_fuse_cut, qual_fuse, FUSE_QUAL_LIM, FLG_FUSE);
    sup_flags[FLG_OVI] = !sup_hold && t.meas_valid && (t.current > cfg_current_max);
    sup_flags[FLG_OVP] = !sup_hold && t.meas_valid && (t.power > cfg_power_max);
    sup_flags[FLG_VOUT] = !sup_hold && t.meas_valid &&
                          (t.voltage > cfg_vout_max || t.voltage < cfg_vout_min);
    if (!t.auto_mode || sup_hold || t.constant_current || !t.meas_valid) begin
      qual_vdev = '0;
      sup_flags[FLG_VDEV] = 1'b0;
    end else begin
      vdiff = int'(t.voltage) - int'(t.voltage_target);
      if (vdiff < 0) vdiff = -vdiff;
      count_fault(vdiff > int'(cfg_vdev_limit), qual_vdev, DEV_QUAL_LIM, FLG_VDEV);
    end
    if (t.auto_mode && t.meas_valid) begin
      i_scaled = 32'(t.current) << 8;
      i_allow  = 32'(t.current_target) * (32'd256 + 32'(cfg_idev_margin));
      count_fault(i_scaled > i_allow, qual_cdev, DEV_QUAL_LIM, FLG_CDEV);
    end
    if (!sup_latch) begin
      sup_drive = 1'b0;
    end else if (sup_flags != 8'd0 || t.init_fail) begin
      sup_drive = 1'b0;
      sup_latch = 1'b0;
    end else begin
      sup_drive = 1'b1;
    end
    r.output_on      = sup_drive;
    r.enable_latched = sup_latch;
    r.starting       = sup_hold;
    r.flags          = sup_flags;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_tick(input in_item_t t);
    return {3'b000, t.user_command, t.init_fail, t.auto_mode, t.constant_current,
            t.current_target, t.voltage_target, t.power, t.current, t.voltage,
            t.temperature};
  endfunction

  task automatic mismatch(input string field, input logic [7:0] exp, input logic [7:0] act);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
    errors++;
  endtask

  task automatic check_status(input out_item_t exp, input logic [OUT_DATA_W-1:0] act);
    if (act[0] !== exp.output_on) mismatch("output_on", exp.output_on, act[0]);
    if (act[1] !== exp.enable_latched) mismatch("enable_latched", exp.enable_latched, act[1]);
    if (act[2] !== exp.starting) mismatch("starting", exp.starting, act[2]);
    for (int i = 0; i < 8; i++)
      if (act[3+i] !== exp.flags[i]) mismatch(flag_names[i], exp.flags[i], act[3+i]);
    if (act[OUT_DATA_W-1:11] !== '0) mismatch("zero fill", 8'd0, 8'(act[OUT_DATA_W-1:11]));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status item with none expected, expected none, actual %0h",
                   $time, out_tdata);
          errors++;
        end else begin
          check_status(expected_status.pop_front(), out_tdata);
        end
      end
      if (in_tvalid && in_tready) expected_status.push_back(supervise_tick(cur_tick));
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(3, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 1) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(10, 1) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_tick(input in_item_t t);
    @(negedge clk);
    if (src_idle && $urandom_range(4, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
    cur_tick   = t;
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(t);
    in_tuser  <= t.meas_valid;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TEMP_LIMIT:  cfg_temp_limit  = val[10:0];
      REG_FUSE_CUT:    cfg_fuse_cut    = val[15:0];
      REG_CURRENT_MAX: cfg_current_max = val[15:0];
      REG_POWER_MAX:   cfg_power_max   = val[19:0];
      REG_VOUT_MAX:    cfg_vout_max    = val[15:0];
      REG_VOUT_MIN:    cfg_vout_min    = val[15:0];
      REG_VDEV_LIMIT:  cfg_vdev_limit  = val[15:0];
      REG_IDEV_MARGIN: cfg_idev_margin = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic user_cmd_t pick_cmd();
    int r;
    r = $urandom_range(999, 0);
    if (r < 3) return CMD_RESTART;
    if (r < 63) return CMD_ENABLE;
    if (r < 83) return CMD_DISABLE;
    return CMD_TICK;
  endfunction

  function automatic in_item_t directed_tick(input int temp_c, input int volt, input int cur,
                                             input int pwr, input int vtgt, input int itgt,
                                             input bit valid, input bit cc, input bit autom,
                                             input bit initf, input user_cmd_t cmd);
    in_item_t t;
    t.temperature      = 12'(temp_c);
    t.voltage          = 16'(volt);
    t.current          = 16'(cur);
    t.power            = 20'(pwr);
    t.voltage_target   = 16'(vtgt);
    t.current_target   = 16'(itgt);
    t.meas_valid       = valid;
    t.constant_current = cc;
    t.auto_mode        = autom;
    t.init_fail        = initf;
    t.user_command     = cmd;
    return t;
  endfunction

  // A healthy tick within the current limits, then bent toward one fault kind.
  function automatic in_item_t make_tick(input fault_kind_t kind);
    in_item_t t;
    int temp_hi;
    int vt;
    int v;
    int it;
    int cap;
    int lo;
    temp_hi = (cfg_temp_limit > 11'd1000) ? 1000 : int'(cfg_temp_limit) - 1;
    if (temp_hi < 0) temp_hi = 0;
    vt = $urandom_range(int'(cfg_vout_max), int'(cfg_vout_min));
    v  = vt + ($urandom_range(1, 0) ? 1 : -1) * int'($urandom_range(cfg_vdev_limit / 2, 0));
    if (v > int'(cfg_vout_max)) v = int'(cfg_vout_max);
    if (v < int'(cfg_vout_min)) v = int'(cfg_vout_min);
    it  = $urandom_range(65535, 100);
    cap = it;
    if (cap > int'(cfg_current_max)) cap = int'(cfg_current_max);
    if (cfg_fuse_cut != 16'd0 && cap > int'(cfg_fuse_cut)) cap = int'(cfg_fuse_cut);
    t.temperature      = 12'($urandom_range(temp_hi, 0));
    t.voltage          = 16'(v);
    t.current          = 16'($urandom_range(cap, 0));
    t.power            = 20'($urandom_range(int'(cfg_power_max), 0));
    t.voltage_target   = 16'(vt);
    t.current_target   = 16'(it);
    t.meas_valid       = ($urandom_range(19, 0) != 0);
    t.constant_current = ($urandom_range(9, 0) == 0);
    t.auto_mode        = ($urandom_range(7, 0) != 0);
    t.init_fail        = ($urandom_range(49, 0) == 0);
    t.user_command     = pick_cmd();
    case (kind)
      FK_TEMP: t.temperature = 12'($urandom_range(1500, int'(cfg_temp_limit)));
      FK_FUSE: begin
        lo = (cfg_fuse_cut == 16'hFFFF) ? 65535 : int'(cfg_fuse_cut) + 1;
        t.current    = 16'($urandom_range(65535, lo));
        t.meas_valid = 1'b1;
      end
      FK_OVI: begin
        lo = (cfg_current_max == 16'hFFFF) ? 65535 : int'(cfg_current_max) + 1;
        t.current    = 16'($urandom_range(65535, lo));
        t.meas_valid = 1'b1;
      end
      FK_OVP: begin
        lo = (cfg_power_max == 20'hFFFFF) ? 1048575 : int'(cfg_power_max) + 1;
        t.power      = 20'($urandom_range(1048575, lo));
        t.meas_valid = 1'b1;
      end
      FK_VOUT: begin
        if ($urandom_range(1, 0) && cfg_vout_min != 16'd0)
          t.voltage = 16'($urandom_range(int'(cfg_vout_min) - 1, 0));
        else
          t.voltage = 16'($urandom_range(65535, (cfg_vout_max == 16'hFFFF) ? 65535 :
                                                int'(cfg_vout_max) + 1));
        t.meas_valid = 1'b1;
      end
      FK_VDEV: begin
        v = int'(cfg_vdev_limit) + 1 + int'($urandom_range(500, 0));
        v = $urandom_range(1, 0) ? vt + v : vt - v;
        if (v > 65535) v = 65535;
        if (v < 0) v = 0;
        t.voltage          = 16'(v);
        t.meas_valid       = 1'b1;
        t.auto_mode        = 1'b1;
        t.constant_current = 1'b0;
      end
      FK_CDEV: begin
        lo = (it * (256 + int'(cfg_idev_margin))) / 256 + 1;
        if (lo > 65535) lo = 65535;
        t.current    = 16'($urandom_range(65535, lo));
        t.meas_valid = 1'b1;
        t.auto_mode  = 1'b1;
      end
      FK_INIT: t.init_fail = 1'b1;
      FK_NOISE: begin
        t.temperature      = 12'($urandom);
        t.voltage          = 16'($urandom);
        t.current          = 16'($urandom);
        t.power            = 20'($urandom);
        t.voltage_target   = 16'($urandom);
        t.current_target   = 16'($urandom);
        t.meas_valid       = 1'($urandom);
        t.constant_current = 1'($urandom);
        t.auto_mode        = 1'($urandom);
        t.init_fail        = 1'($urandom);
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic run_ticks(input int n);
    fault_kind_t kind;
    int          left;
    kind = FK_NONE;
    left = 0;
    repeat (n) begin
      if (left == 0) begin
        if ($urandom_range(2, 0) == 0) kind = fault_kind_t'($urandom_range(FK_NOISE, FK_TEMP));
        else kind = FK_NONE;
        left = (kind == FK_NONE) ? $urandom_range(30, 5) : $urandom_range(6, 1);
      end
      send_tick(make_tick(kind));
      left--;
    end
  endtask

  task automatic apply_config(input int setting);
    drain();
    case (setting)
      1: begin
        write_reg(REG_TEMP_LIMIT, 0);
        write_reg(REG_FUSE_CUT, 0);
        write_reg(REG_CURRENT_MAX, 0);
        write_reg(REG_POWER_MAX, 0);
        write_reg(REG_VOUT_MAX, 0);
        write_reg(REG_VOUT_MIN, 0);
        write_reg(REG_VDEV_LIMIT, 0);
        write_reg(REG_IDEV_MARGIN, 0);
      end
      3: begin
        write_reg(REG_TEMP_LIMIT, 1500);
        write_reg(REG_FUSE_CUT, 65535);
        write_reg(REG_CURRENT_MAX, 65535);
        write_reg(REG_POWER_MAX, 1048575);
        write_reg(REG_VOUT_MAX, 65535);
        write_reg(REG_VOUT_MIN, 65535);
        write_reg(REG_VDEV_LIMIT, 65535);
        write_reg(REG_IDEV_MARGIN, 255);
      end
      default: begin
        write_reg(REG_TEMP_LIMIT, $urandom_range(1200, 400));
        write_reg(REG_FUSE_CUT, ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(20000, 2000));
        write_reg(REG_CURRENT_MAX, $urandom_range(40000, 5000));
        write_reg(REG_POWER_MAX, $urandom_range(800000, 100000));
        write_reg(REG_VOUT_MAX, $urandom_range(50000, 20000));
        write_reg(REG_VOUT_MIN, $urandom_range(3000, 0));
        write_reg(REG_VDEV_LIMIT, $urandom_range(3000, 100));
        write_reg(REG_IDEV_MARGIN, $urandom_range(255, 0));
      end
    endcase
  endtask

  task automatic test_directed();
    send_tick(directed_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_TICK));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_ENABLE));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_TICK));
    repeat (3) send_tick(directed_tick(1500, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0,
                                       CMD_TICK));
    send_tick(directed_tick(-400, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_ENABLE));
    send_tick(directed_tick(0, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_ENABLE));
    send_tick(directed_tick(1000, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_TICK));
    send_tick(directed_tick(1001, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_TICK));
    send_tick(directed_tick(599, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_ENABLE));
    send_tick(directed_tick(600, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_TICK));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 1, CMD_ENABLE));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_DISABLE));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_ENABLE));
    repeat (3) send_tick(directed_tick(250, 65535, 65535, 1048575, 65535, 0, 1, 0, 1, 0,
                                       CMD_TICK));
    send_tick(directed_tick(250, 65535, 0, 0, 0, 65535, 0, 0, 1, 0, CMD_TICK));
    send_tick(directed_tick(250, 65535, 0, 0, 0, 65535, 1, 0, 0, 0, CMD_TICK));
    send_tick(directed_tick(250, 0, 0, 0, 65535, 65535, 1, 1, 1, 0, CMD_TICK));
    send_tick(directed_tick(250, 12000, 500, 6000, 12000, 1000, 1, 0, 1, 0, CMD_RESTART));
    drain();
    write_reg(REG_FUSE_CUT, 100);
    send_tick(directed_tick(250, 12000, 65535, 6000, 12000, 65535, 1, 0, 1, 0, CMD_ENABLE));
    send_tick(directed_tick(250, 12000, 65535, 6000, 12000, 65535, 1, 0, 1, 0, CMD_TICK));
    send_tick(directed_tick(250, 12000, 65535, 6000, 12000, 65535, 0, 0, 1, 0, CMD_TICK));
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    src_idle = 1'b0;
    run_ticks(40);
    src_idle = 1'b1;
    drain();
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 6; s++) begin
      apply_config(s);
      run_ticks(290);
    end
  endtask

  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_ticks(150);
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_TEMP_LIMIT;
    cfg_wdata = '0;
    errors       = 0;
    stall_cycles = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    hold_req     = 1'b0;
    cfg_temp_limit  = 11'd600;
    cfg_fuse_cut    = 16'd0;
    cfg_current_max = 16'hFFFF;
    cfg_power_max   = 20'hFFFFF;
    cfg_vout_max    = 16'hFFFF;
    cfg_vout_min    = 16'd0;
    cfg_vdev_limit  = 16'd1000;
    cfg_idev_margin = 8'd26;
    clear_supervision();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_settings();
    test_full_rate();

    drain();
    repeat (8) @(posedge clk);
    errors += expected_status.size();
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
